// File: rtl/lzssd_pkg.sv
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the flag-byte LZSS decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

  localparam int DEFAULT_WINDOW_SIZE = 4096;
  localparam int DEFAULT_SIZE_BITS   = 24;

  localparam int RAW_SIZE_W = 24;
  localparam int BYTE_W     = 8;
  localparam int DIST_W     = 12;
  localparam int LEN_W      = 5;
  localparam int FLAG_CNT_W = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_W-1:0]      MIN_MATCH   = 5'd3;
  localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_BYTE = 4'd8;

  // register index, taken from paddr[2]
  localparam logic REG_RAW_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_FLAG,   // next byte is a flag byte
    ST_LIT,    // next byte is a literal
    ST_MHI,    // next byte is the first match byte
    ST_MLO,    // next byte is the second match byte
    ST_COPY,   // copying match bytes from history
    ST_HALT    // done or error, drop input until reset
  } dec_state_t;

endpackage

// File: rtl/lzssd_ram.sv
// ----------------------------------------------------------------------------
// lzssd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lzss_flag_byte_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor
// LZSS decoder with flag bytes, 12-bit distances and a history ring in RAM.
// ----------------------------------------------------------------------------
// Feed the packed stream that follows the 8-byte header, one byte per word on
// the slave side; decompressed bytes leave on the master side, the final one
// with tlast. A bad match distance gives a single word with tuser (error) and
// tlast set and a zero byte. Flag, literal and match-header bytes are taken at
// one per cycle while the output register is free. A match then holds the
// input until its bytes (3 to 18) are copied: the copy reads history RAM one
// byte ahead and writes each byte back in the same cycle, so the single RAM
// write port sets the rate to one output byte per cycle while output is free.
// Write raw_size only while idle. After the final byte or an error all input
// is accepted and dropped until reset. The history RAM is not cleared after
// reset; a valid stream only reads entries it has written.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decompressor
  import lzssd_pkg::*;
#(
  parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE,
  parameter int SIZE_BITS   = DEFAULT_SIZE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // packed stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] packed_byte
  // decompressed stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,    // [7:0] out_byte
  output logic                  m_tlast,
  output logic                  m_tuser,    // [0] error
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_SIZE - 1);
  localparam logic [AW:0]   WIN_SPAN  = (AW + 1)'(WINDOW_SIZE);

  dec_state_t state, state_next;

  logic [BYTE_W-1:0]     flag_bits, flag_bits_next;
  logic [FLAG_CNT_W-1:0] flags_left, flags_left_next;
  logic [BYTE_W-1:0]     match_high, match_high_next;
  logic [SIZE_BITS-1:0]  produced, produced_next;
  logic [AW-1:0]         wptr, wptr_next;
  logic [AW-1:0]         copy_src, copy_src_next;
  logic [LEN_W-1:0]      copy_left, copy_left_next;
  logic [RAW_SIZE_W-1:0] raw_size;

  logic                  out_valid, out_valid_next;
  logic [BYTE_W-1:0]     out_byte, out_byte_next;
  logic                  out_last, out_last_next;
  logic                  out_error, out_error_next;

  logic                  fwd_hit, fwd_hit_next;
  logic [BYTE_W-1:0]     fwd_data, fwd_data_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata;
  logic [BYTE_W-1:0]     ram_rdata;

  logic                  out_free;
  logic                  in_acc;
  logic [SIZE_BITS-1:0]  lim;
  logic [SIZE_BITS-1:0]  prod_inc;
  logic                  emit_done;
  logic [DIST_W-1:0]     match_dist;
  logic                  bad_dist;
  logic [AW:0]           src_diff;
  logic [AW-1:0]         src0;
  logic [BYTE_W-1:0]     copy_data;
  dec_state_t            tok_state;
  logic [BYTE_W-1:0]     tok_flag_bits;
  logic [FLAG_CNT_W-1:0] tok_flags_left;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  lzssd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RAW_SIZE) ? APB_DATA_W'(raw_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_size <= RAW_SIZE_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RAW_SIZE) begin
      raw_size <= pwdata[RAW_SIZE_W-1:0];
    end
  end

  assign out_free   = !out_valid || m_tready;
  assign s_tready   = (state == ST_HALT) || (state != ST_COPY && out_free);
  assign in_acc     = s_tvalid && s_tready;
  assign lim        = SIZE_BITS'(raw_size);
  assign prod_inc   = produced + 1'b1;
  assign emit_done  = (prod_inc >= lim);
  assign match_dist = {match_high[7:4], s_tdata};
  assign bad_dist   = (match_dist == '0) || (SIZE_BITS'(match_dist) > produced);
  assign src_diff   = {1'b0, wptr} - (AW + 1)'(match_dist);
  assign src0       = src_diff[AW] ? AW'(src_diff + WIN_SPAN) : src_diff[AW-1:0];
  assign copy_data  = fwd_hit ? fwd_data : ram_rdata;

  // take the next flag bit, MSB first
  always_comb begin
    tok_flag_bits  = {flag_bits[BYTE_W-2:0], 1'b0};
    tok_flags_left = flags_left - 1'b1;
    if (flags_left == '0) begin
      tok_state      = ST_FLAG;
      tok_flag_bits  = flag_bits;
      tok_flags_left = flags_left;
    end else if (flag_bits[BYTE_W-1]) begin
      tok_state = ST_MHI;
    end else begin
      tok_state = ST_LIT;
    end
  end

  always_comb begin
    state_next      = state;
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    match_high_next = match_high;
    produced_next   = produced;
    wptr_next       = wptr;
    copy_src_next   = copy_src;
    copy_left_next  = copy_left;
    out_valid_next  = out_valid && !m_tready;
    out_byte_next   = out_byte;
    out_last_next   = out_last;
    out_error_next  = out_error;
    ram_we          = 1'b0;
    ram_wdata       = s_tdata;
    ram_raddr       = copy_src;

    unique case (state)
      ST_HALT: begin
        // drop input
      end
      ST_COPY: begin
        if (out_free) begin
          ram_we         = 1'b1;
          ram_wdata      = copy_data;
          produced_next  = prod_inc;
          wptr_next      = ring_inc(wptr);
          out_valid_next = 1'b1;
          out_byte_next  = copy_data;
          out_last_next  = emit_done;
          out_error_next = 1'b0;
          // read one byte ahead
          copy_src_next  = ring_inc(copy_src);
          ram_raddr      = ring_inc(copy_src);
          copy_left_next = copy_left - 1'b1;
          if (emit_done) begin
            state_next = ST_HALT;
          end else if (copy_left == LEN_W'(1)) begin
            state_next      = tok_state;
            flag_bits_next  = tok_flag_bits;
            flags_left_next = tok_flags_left;
          end
        end
      end
      default: begin
        if (in_acc) begin
          if (produced >= lim) begin
            state_next = ST_HALT;
          end else begin
            unique case (state)
              ST_FLAG: begin
                state_next      = s_tdata[BYTE_W-1] ? ST_MHI : ST_LIT;
                flag_bits_next  = {s_tdata[BYTE_W-2:0], 1'b0};
                flags_left_next = FLAGS_PER_BYTE - 1'b1;
              end
              ST_LIT: begin
                ram_we         = 1'b1;
                produced_next  = prod_inc;
                wptr_next      = ring_inc(wptr);
                out_valid_next = 1'b1;
                out_byte_next  = s_tdata;
                out_last_next  = emit_done;
                out_error_next = 1'b0;
                if (emit_done) begin
                  state_next = ST_HALT;
                end else begin
                  state_next      = tok_state;
                  flag_bits_next  = tok_flag_bits;
                  flags_left_next = tok_flags_left;
                end
              end
              ST_MHI: begin
                match_high_next = s_tdata;
                state_next      = ST_MLO;
              end
              default: begin
                if (bad_dist) begin
                  out_valid_next = 1'b1;
                  out_byte_next  = '0;
                  out_last_next  = 1'b1;
                  out_error_next = 1'b1;
                  state_next     = ST_HALT;
                end else begin
                  copy_src_next  = src0;
                  ram_raddr      = src0;
                  copy_left_next = {1'b0, match_high[3:0]} + MIN_MATCH;
                  state_next     = ST_COPY;
                end
              end
            endcase
          end
        end
      end
    endcase

    // a read of the entry written in the same cycle returns stale data
    fwd_hit_next  = ram_we && (ram_raddr == wptr);
    fwd_data_next = ram_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FLAG;
      flag_bits  <= '0;
      flags_left <= '0;
      produced   <= '0;
      wptr       <= '0;
      out_valid  <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      state      <= state_next;
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
      produced   <= produced_next;
      wptr       <= wptr_next;
      out_valid  <= out_valid_next;
      fwd_hit    <= fwd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    match_high <= match_high_next;
    copy_src   <= copy_src_next;
    copy_left  <= copy_left_next;
    out_byte   <= out_byte_next;
    out_last   <= out_last_next;
    out_error  <= out_error_next;
    fwd_data   <= fwd_data_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = out_error;

endmodule

// File: rtl/lzssd_checker.sv
// ----------------------------------------------------------------------------
// lzssd_checker
// Port-level checks of the decompressor output stream.
// ----------------------------------------------------------------------------
module lzssd_checker
  import lzssd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [BYTE_W-1:0] m_tdata,
  input logic              m_tlast,
  input logic              m_tuser
);

  // an error word ends the stream
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("error word without tlast");

  // an error word carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("error word with nonzero data");

  // no valid word directly follows the last word
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("word after tlast");

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser)))
    else $error("stalled word changed");

endmodule

bind lzss_flag_byte_decompressor lzssd_checker u_lzssd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: dv/lzss_flag_byte_decompressor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor_test
// Feeds packed LZSS token streams into the decompressor and checks every
// output word against a behavioral decoder kept in the bench. Covers literals,
// overlapping and boundary matches, history ring wrap, raw size changes, and
// one randomly chosen way of ending the stream (final byte, bad distance or
// raw size change), followed by input that must be dropped.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decompressor_test;
  import lzssd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [APB_ADDR_W-1:0] RAW_SIZE_ADDR = {REG_RAW_SIZE, 2'b00};

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              is_last;
    logic              is_error;
  } out_word_t;

  typedef enum int {
    END_CUT_SHORT,
    END_ZERO_DIST,
    END_FAR_DIST,
    END_SIZE_LOWERED,
    END_SIZE_ZERO
  } end_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;      // [7:0] packed_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;           // [7:0] out_byte
  logic                  m_tlast;
  logic                  m_tuser;           // [0] error
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // decoder state mirrored in the bench
  logic [BYTE_W-1:0]     hist_mem [0:DEFAULT_WINDOW_SIZE-1];
  logic [BYTE_W-1:0]     flag_reg = '0;
  logic [FLAG_CNT_W-1:0] flags_rem = '0;
  dec_state_t            tok_state = ST_FLAG;
  logic [BYTE_W-1:0]     mhi_reg = '0;
  logic [RAW_SIZE_W-1:0] out_count = '0;
  logic                  stopped = 1'b0;
  logic [RAW_SIZE_W-1:0] size_cfg = 24'd1;

  out_word_t due_words [$];
  int        fails = 0;
  int        sent_words = 0;
  int        stall_left = 0;
  bit        src_gaps = 1'b0;
  bit        sink_gaps = 1'b0;
  end_kind_t stream_end;

  lzss_flag_byte_decompressor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Behavioral decoder
  // -------------------------------------------------------------------------
  task automatic take_flag_bit();
    if (flags_rem == 0) begin
      tok_state = ST_FLAG;
    end else begin
      tok_state = flag_reg[7] ? ST_MHI : ST_LIT;
      flag_reg  = flag_reg << 1;
      flags_rem = flags_rem - 1'b1;
    end
  endtask

  task automatic emit_byte(input logic [BYTE_W-1:0] b, output logic done);
    out_word_t w;
    hist_mem[out_count[DIST_W-1:0]] = b;
    out_count = out_count + 1'b1;
    done = (out_count >= size_cfg);
    w.byte_val = b;
    w.is_last  = done;
    w.is_error = 1'b0;
    due_words.push_back(w);
    if (done) stopped = 1'b1;
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [DIST_W-1:0] match_dist;
    logic [DIST_W-1:0] src;
    logic [LEN_W-1:0]  count;
    logic              done;
    int                k;
    done = 1'b0;
    if (stopped) begin
      // drop everything until reset
    end else if (out_count >= size_cfg) begin
      stopped = 1'b1;
    end else begin
      case (tok_state)
        ST_FLAG: begin
          flag_reg  = b;
          flags_rem = FLAGS_PER_BYTE;
          take_flag_bit();
        end
        ST_LIT: begin
          emit_byte(b, done);
          if (!done) take_flag_bit();
        end
        ST_MHI: begin
          mhi_reg   = b;
          tok_state = ST_MLO;
        end
        default: begin
          match_dist = {mhi_reg[7:4], b};
          count      = {1'b0, mhi_reg[3:0]} + MIN_MATCH;
          if (match_dist == 0 || match_dist > out_count) begin
            due_words.push_back('{byte_val: '0, is_last: 1'b1, is_error: 1'b1});
            stopped = 1'b1;
          end else begin
            for (k = 0; k < count && !done; k++) begin
              src = out_count[DIST_W-1:0] - match_dist;
              emit_byte(hist_mem[src], done);
            end
            if (!done) take_flag_bit();
          end
        end
      endcase
    end
  endtask

  // Predict on each accepted input word, then check the output word.
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) decode_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (due_words.size() == 0) begin
          $error("unexpected output word: out_byte %0h last %0b error %0b",
                 m_tdata, m_tlast, m_tuser);
          fails++;
        end else begin
          want = due_words.pop_front();
          if (m_tdata !== want.byte_val) begin
            $error("out_byte: expected %0h, got %0h", want.byte_val, m_tdata);
            fails++;
          end
          if (m_tlast !== want.is_last) begin
            $error("last: expected %0b, got %0b", want.is_last, m_tlast);
            fails++;
          end
          if (m_tuser !== want.is_error) begin
            $error("error: expected %0b, got %0b", want.is_error, m_tuser);
            fails++;
          end
        end
      end
    end
  end

  // Output side back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Drivers; all called and returning at a falling edge
  // -------------------------------------------------------------------------
  task automatic send_word(input logic [BYTE_W-1:0] b);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_words++;
  endtask

  // Drop valid, drain all expected words, then let the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_raw_size(input logic [RAW_SIZE_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RAW_SIZE_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_cfg = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[RAW_SIZE_W-1:0] !== v) begin
      $error("raw_size: expected %0h, got %0h", v, rd[RAW_SIZE_W-1:0]);
      fails++;
    end
  endtask

  // One flag word and its eight tokens, with legal distances only.
  task automatic send_group(input int match_pct, input int long_pct);
    logic [7:0]        flags;
    logic [DIST_W-1:0] match_dist;
    logic [3:0]        len_code;
    int                far;
    int                i;
    for (i = 0; i < 8; i++) flags[i] = ($urandom_range(0, 99) < match_pct);
    if (out_count == 0) flags[7] = 1'b0;
    send_word(flags);
    for (i = 7; i >= 0; i--) begin
      if (flags[i]) begin
        far = (out_count > 4095) ? 4095 : int'(out_count);
        case ($urandom_range(0, 7))
          0:       match_dist = 1;
          1:       match_dist = far;
          default: match_dist = $urandom_range(1, far);
        endcase
        len_code = ($urandom_range(0, 99) < long_pct) ? 4'hF : 4'($urandom_range(0, 15));
        send_word({match_dist[11:8], len_code});
        send_word(match_dist[7:0]);
      end else begin
        send_word(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_literals_and_matches();
    logic [7:0] lits [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    write_raw_size(24'hFFFFFF);
    send_word(8'h00);
    foreach (lits[i]) send_word(lits[i]);
    send_word(8'hF0);
    // distance 1 with 18 bytes: copy overlaps its own output
    send_word(8'h0F);
    send_word(8'h01);
    // distance equal to everything produced so far
    send_word(8'h00);
    send_word(8'h1A);
    send_word(8'h0A);
    send_word(8'h05);
    send_word(8'h07);
    send_word(8'h2A);
    send_word(8'h11);
    send_word(8'h22);
    send_word(8'h44);
    send_word(8'h88);
    wait_idle();
  endtask

  task automatic test_random_tokens();
    int start;
    start     = sent_words;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    while (sent_words - start < 70) send_group(40, 30);
    wait_idle();
    write_raw_size(24'h800000);
  endtask

  // Long matches until the history ring has wrapped; no bad distance can
  // follow a wrap, so that ending stops short of it.
  task automatic test_history_wrap();
    int target;
    target    = (stream_end == END_FAR_DIST) ? 3000 : DEFAULT_WINDOW_SIZE + 300;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    while (out_count < target / 2) send_group(85, 80);
    wait_idle();
    write_raw_size(24'h010000);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    while (out_count < target) send_group(90, 90);
    wait_idle();
  endtask

  task automatic test_stream_end();
    logic [DIST_W-1:0] match_dist;
    case (stream_end)
      END_CUT_SHORT: begin
        write_raw_size(out_count + RAW_SIZE_W'($urandom_range(1, 18)));
        send_word(8'hFF);
        send_word(8'h0F);
        send_word(8'h01);
      end
      END_ZERO_DIST: begin
        send_word(8'h80);
        send_word(8'($urandom_range(0, 15)));
        send_word(8'h00);
      end
      END_FAR_DIST: begin
        match_dist = $urandom_range(int'(out_count) + 1, 4095);
        send_word(8'h80);
        send_word({match_dist[11:8], 4'($urandom_range(0, 15))});
        send_word(match_dist[7:0]);
      end
      END_SIZE_LOWERED: begin
        if ($urandom_range(0, 1) == 0)
          write_raw_size(24'd1);
        else
          write_raw_size(RAW_SIZE_W'($urandom_range(1, int'(out_count))));
        send_word(8'h00);
        send_word(8'($urandom_range(0, 255)));
      end
      default: begin
        write_raw_size(24'd0);
        send_word(8'h00);
        send_word(8'($urandom_range(0, 255)));
      end
    endcase
    wait_idle();
  endtask

  // Once halted, input is taken and dropped, even after a new raw_size.
  task automatic test_halted_input();
    repeat (16) send_word(8'($urandom_range(0, 255)));
    wait_idle();
    write_raw_size(24'hFFFFFF);
    send_word(8'h00);
    repeat (8) send_word(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  initial begin
    stream_end = end_kind_t'($urandom_range(0, 4));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_literals_and_matches();
    test_random_tokens();
    test_history_wrap();
    test_stream_end();
    test_halted_input();
    if (due_words.size() != 0) begin
      $error("%0d expected output words never arrived", due_words.size());
      fails++;
    end
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
